>>> src/sgi_pkg.sv
// ----------------------------------------------------------------------------
// sgi_pkg
// Shared constants of the segment intersection block: output width, the
// quotient magnitude limit and the Q-format saturation bounds.
// ----------------------------------------------------------------------------
`default_nettype none

package sgi_pkg;

	localparam int OUT_BITS = 32;
	// quotients at or above 2^QBIG_BIT count as out of range
	localparam int QBIG_BIT = 62;
	localparam logic signed [OUT_BITS-1:0] SAT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam logic signed [OUT_BITS-1:0] SAT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

endpackage

`default_nettype wire

>>> src/sgi_div_cell.sv
// ----------------------------------------------------------------------------
// sgi_div_cell
// One restoring division step: shifts one dividend bit into the partial
// remainder, subtracts the divisor when it fits and records the quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_div_cell #(
	parameter int D = 35,
	parameter int N = 68
) (
	input  wire logic         clk,
	input  wire logic [D-1:0] rem_in,
	input  wire logic [N-1:0] num_in,
	input  wire logic [D-1:0] den_in,
	output logic      [D-1:0] rem_q,
	output logic      [N-1:0] num_q,
	output logic      [D-1:0] den_q
);

	logic [D:0]   trial;
	logic [D:0]   diff;
	logic         fits;

	always_comb begin
		trial = {rem_in, num_in[N-1]};
		diff  = trial - {1'b0, den_in};
		fits  = trial >= {1'b0, den_in};
	end

	always_ff @(posedge clk) begin
		rem_q <= fits ? diff[D-1:0] : trial[D-1:0];
		num_q <= {num_in[N-2:0], fits};
		den_q <= den_in;
	end

endmodule

`default_nettype wire

>>> src/sgi_divider.sv
// ----------------------------------------------------------------------------
// sgi_divider
// Unsigned divider built as a row of N division cells, one quotient bit per
// cell; takes a new operand pair every cycle, each cell registers its step.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_divider #(
	parameter int D = 35,
	parameter int N = 68
) (
	input  wire logic         clk,
	input  wire logic [N-1:0] num,
	input  wire logic [D-1:0] den,
	output logic      [N-1:0] quot
);

	logic [D-1:0] rem_c [N+1];
	logic [N-1:0] num_c [N+1];
	logic [D-1:0] den_c [N+1];

	assign rem_c[0] = '0;
	assign num_c[0] = num;
	assign den_c[0] = den;

	for (genvar k = 0; k < N; k++) begin : g_cell
		sgi_div_cell #(.D(D), .N(N)) u_cell (
			.clk    (clk),
			.rem_in (rem_c[k]),
			.num_in (num_c[k]),
			.den_in (den_c[k]),
			.rem_q  (rem_c[k+1]),
			.num_q  (num_c[k+1]),
			.den_q  (den_c[k+1])
		);
	end

	assign quot = num_c[N];

endmodule

`default_nettype wire

>>> src/segment_intersection_top.sv
// ----------------------------------------------------------------------------
// segment_intersection_top
// Intersection of two 2D segments in signed fixed point, with parallel, hit
// and saturation flags.
// ----------------------------------------------------------------------------
// The quotients come from a row of division cells, one quotient bit per cell.
// Throughput: one word per cycle; busy stays low.
// Results appear with done for one cycle; the receiver cannot stall.
// Reset clears the valid pipeline only; no word is lost after reset.
`default_nettype none

module segment_intersection_top #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] first_start_x,
	input  wire logic signed [COORD_BITS-1:0] first_start_y,
	input  wire logic signed [COORD_BITS-1:0] first_end_x,
	input  wire logic signed [COORD_BITS-1:0] first_end_y,
	input  wire logic signed [COORD_BITS-1:0] second_start_x,
	input  wire logic signed [COORD_BITS-1:0] second_start_y,
	input  wire logic signed [COORD_BITS-1:0] second_end_x,
	input  wire logic signed [COORD_BITS-1:0] second_end_y,
	output logic                              done,
	output logic                              hit,
	output logic                              parallel,
	output logic signed [sgi_pkg::OUT_BITS-1:0] cross_x,
	output logic signed [sgi_pkg::OUT_BITS-1:0] cross_y,
	output logic                              clipped
);

	localparam int C    = COORD_BITS;
	localparam int AW   = C + 1;
	localparam int PW   = 2 * C + 2;
	localparam int DW   = 2 * C + 3;
	localparam int QW   = 3 * C + 3;
	localparam int NW   = 3 * C + 4;
	localparam int N    = NW + FRAC_BITS;
	localparam int EW   = 8 * C;
	localparam int LAT  = 8 + N;
	localparam int EXTD = 5 + N;
	localparam int OW   = sgi_pkg::OUT_BITS;

	// stage 1: line coefficients and extents
	logic signed [AW-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [C-1:0]  x1_s1, y1_s1, x2_s1, y2_s1;
	logic [EW-1:0]        ext_s1;

	// stage 2: first products
	logic signed [PW-1:0] pa1_s2, pb1_s2, pa2_s2, pb2_s2, d1_s2, d2_s2;
	logic signed [AW-1:0] a1_s2, b1_s2, a2_s2, b2_s2;

	// stage 3: c terms and determinant
	logic signed [PW-1:0] c1_s3, c2_s3;
	logic signed [DW-1:0] det_s3;
	logic signed [AW-1:0] a1_s3, b1_s3, a2_s3, b2_s3;

	// stage 4: numerator products
	logic signed [QW-1:0] px1_s4, px2_s4, py1_s4, py2_s4;
	logic signed [DW-1:0] det_s4;

	// stage 5: numerators
	logic signed [NW-1:0] numx_s5, numy_s5;
	logic signed [DW-1:0] det_s5;

	// stage 6: magnitudes and signs
	logic [N-1:0]  magx_s6, magy_s6;
	logic [DW-1:0] dmag_s6;
	logic          negx_s6, negy_s6, par_s6;

	logic [N-1:0]  qx, qy;

	logic [EW-1:0] ext_q  [EXTD];
	logic [2:0]    flag_q [N];
	logic [LAT-1:0] vld_q;

	// back end
	logic signed [63:0] vx_b1, vy_b1;
	logic               bigx_b1, bigy_b1, negx_b1, negy_b1, par_b1;
	logic [EW-1:0]      ext_b1;

	logic [63:0]        mgx, mgy;
	logic signed [C-1:0] ex [8];
	logic signed [63:0] lim [8];
	logic               inx1, inx2, iny1, iny2, hit_d;
	logic signed [OW-1:0] sx, sy;
	logic               clx, cly;

	assign busy = 1'b0;

	always_ff @(posedge clk) begin
		a1_s1  <= AW'(first_end_y) - AW'(first_start_y);
		b1_s1  <= AW'(first_start_x) - AW'(first_end_x);
		a2_s1  <= AW'(second_end_y) - AW'(second_start_y);
		b2_s1  <= AW'(second_start_x) - AW'(second_end_x);
		x1_s1  <= first_start_x;
		y1_s1  <= first_start_y;
		x2_s1  <= second_start_x;
		y2_s1  <= second_start_y;
		ext_s1 <= {
			(first_start_x < first_end_x) ? first_start_x : first_end_x,
			(first_start_x < first_end_x) ? first_end_x : first_start_x,
			(second_start_x < second_end_x) ? second_start_x : second_end_x,
			(second_start_x < second_end_x) ? second_end_x : second_start_x,
			(first_start_y < first_end_y) ? first_start_y : first_end_y,
			(first_start_y < first_end_y) ? first_end_y : first_start_y,
			(second_start_y < second_end_y) ? second_start_y : second_end_y,
			(second_start_y < second_end_y) ? second_end_y : second_start_y
		};

		pa1_s2 <= PW'(a1_s1) * PW'(x1_s1);
		pb1_s2 <= PW'(b1_s1) * PW'(y1_s1);
		pa2_s2 <= PW'(a2_s1) * PW'(x2_s1);
		pb2_s2 <= PW'(b2_s1) * PW'(y2_s1);
		d1_s2  <= PW'(a1_s1) * PW'(b2_s1);
		d2_s2  <= PW'(a2_s1) * PW'(b1_s1);
		a1_s2  <= a1_s1;
		b1_s2  <= b1_s1;
		a2_s2  <= a2_s1;
		b2_s2  <= b2_s1;

		c1_s3  <= -(pa1_s2 + pb1_s2);
		c2_s3  <= -(pa2_s2 + pb2_s2);
		det_s3 <= DW'(d1_s2) - DW'(d2_s2);
		a1_s3  <= a1_s2;
		b1_s3  <= b1_s2;
		a2_s3  <= a2_s2;
		b2_s3  <= b2_s2;

		px1_s4 <= QW'(b1_s3) * QW'(c2_s3);
		px2_s4 <= QW'(c1_s3) * QW'(b2_s3);
		py1_s4 <= QW'(a2_s3) * QW'(c1_s3);
		py2_s4 <= QW'(a1_s3) * QW'(c2_s3);
		det_s4 <= det_s3;

		numx_s5 <= NW'(px1_s4) - NW'(px2_s4);
		numy_s5 <= NW'(py1_s4) - NW'(py2_s4);
		det_s5  <= det_s4;

		magx_s6 <= {(numx_s5[NW-1] ? NW'(-numx_s5) : NW'(numx_s5)), {FRAC_BITS{1'b0}}};
		magy_s6 <= {(numy_s5[NW-1] ? NW'(-numy_s5) : NW'(numy_s5)), {FRAC_BITS{1'b0}}};
		dmag_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
		negx_s6 <= numx_s5[NW-1] ^ det_s5[DW-1];
		negy_s6 <= numy_s5[NW-1] ^ det_s5[DW-1];
		par_s6  <= det_s5 == '0;
	end

	sgi_divider #(.D(DW), .N(N)) u_divx (
		.clk  (clk),
		.num  (magx_s6),
		.den  (dmag_s6),
		.quot (qx)
	);

	sgi_divider #(.D(DW), .N(N)) u_divy (
		.clk  (clk),
		.num  (magy_s6),
		.den  (dmag_s6),
		.quot (qy)
	);

	// hold side data alongside the divider row
	always_ff @(posedge clk) begin
		ext_q[0]  <= ext_s1;
		flag_q[0] <= {par_s6, negy_s6, negx_s6};
		for (int k = 1; k < EXTD; k++) begin
			ext_q[k] <= ext_q[k-1];
		end
		for (int k = 1; k < N; k++) begin
			flag_q[k] <= flag_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	always_comb begin
		mgx = 64'(qx);
		mgy = 64'(qy);
	end

	always_ff @(posedge clk) begin
		bigx_b1 <= (qx >> sgi_pkg::QBIG_BIT) != '0;
		bigy_b1 <= (qy >> sgi_pkg::QBIG_BIT) != '0;
		vx_b1   <= flag_q[N-1][0] ? -$signed(mgx) : $signed(mgx);
		vy_b1   <= flag_q[N-1][1] ? -$signed(mgy) : $signed(mgy);
		negx_b1 <= flag_q[N-1][0];
		negy_b1 <= flag_q[N-1][1];
		par_b1  <= flag_q[N-1][2];
		ext_b1  <= ext_q[EXTD-1];
	end

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			ex[k]  = $signed(ext_b1[EW-1-k*C -: C]);
			lim[k] = 64'(ex[k]) <<< FRAC_BITS;
		end
		inx1  = !bigx_b1 && vx_b1 >= lim[0] && vx_b1 <= lim[1];
		inx2  = !bigx_b1 && vx_b1 >= lim[2] && vx_b1 <= lim[3];
		iny1  = !bigy_b1 && vy_b1 >= lim[4] && vy_b1 <= lim[5];
		iny2  = !bigy_b1 && vy_b1 >= lim[6] && vy_b1 <= lim[7];
		hit_d = inx1 && inx2 && iny1 && iny2;

		clx = 1'b1;
		priority if (bigx_b1) begin
			sx = negx_b1 ? sgi_pkg::SAT_MIN : sgi_pkg::SAT_MAX;
		end else if (vx_b1 > 64'(sgi_pkg::SAT_MAX)) begin
			sx = sgi_pkg::SAT_MAX;
		end else if (vx_b1 < 64'(sgi_pkg::SAT_MIN)) begin
			sx = sgi_pkg::SAT_MIN;
		end else begin
			sx  = vx_b1[OW-1:0];
			clx = 1'b0;
		end

		cly = 1'b1;
		priority if (bigy_b1) begin
			sy = negy_b1 ? sgi_pkg::SAT_MIN : sgi_pkg::SAT_MAX;
		end else if (vy_b1 > 64'(sgi_pkg::SAT_MAX)) begin
			sy = sgi_pkg::SAT_MAX;
		end else if (vy_b1 < 64'(sgi_pkg::SAT_MIN)) begin
			sy = sgi_pkg::SAT_MIN;
		end else begin
			sy  = vy_b1[OW-1:0];
			cly = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		parallel <= par_b1;
		hit      <= !par_b1 && hit_d;
		clipped  <= !par_b1 && (clx || cly);
		cross_x  <= par_b1 ? '0 : sx;
		cross_y  <= par_b1 ? '0 : sy;
	end

	assign done = vld_q[LAT-1];

endmodule

`default_nettype wire

>>> src/sgi_checker.sv
// ----------------------------------------------------------------------------
// sgi_checker
// Port-level checks of the segment intersection block: fixed latency and
// consistency of the result flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_checker #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         done,
	input wire logic                         hit,
	input wire logic                         parallel,
	input wire logic [sgi_pkg::OUT_BITS-1:0] cross_x,
	input wire logic [sgi_pkg::OUT_BITS-1:0] cross_y,
	input wire logic                         clipped
);

	localparam int LAT = 8 + 3 * COORD_BITS + 4 + FRAC_BITS;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a word accepted one latency earlier");

	a_parallel: assert property (@(posedge clk) disable iff (!arst_n)
		done && parallel |-> !hit && !clipped && cross_x == '0 && cross_y == '0)
		else $error("parallel result carries a point or flags");

	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !parallel && !clipped)
		else $error("hit on a parallel or saturated result");

	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		done && clipped |->
			cross_x == sgi_pkg::SAT_MAX || cross_x == sgi_pkg::SAT_MIN ||
			cross_y == sgi_pkg::SAT_MAX || cross_y == sgi_pkg::SAT_MIN)
		else $error("clipped without a saturated coordinate");

endmodule

bind segment_intersection_top sgi_checker #(
	.COORD_BITS (COORD_BITS),
	.FRAC_BITS  (FRAC_BITS)
) u_sgi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.hit      (hit),
	.parallel (parallel),
	.cross_x  (cross_x),
	.cross_y  (cross_y),
	.clipped  (clipped)
);

`default_nettype wire
